### rtl/prt_pkg.sv
// Shared types, command codes and divider tap tables for the prescaled timer.
package prt_pkg;

  localparam int DivW  = 16;
  localparam int ByteW = 8;
  localparam int CtrlW = 3;

  // Command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_DIV  = 2'd0;
  localparam logic [1:0] REG_TIMA = 2'd1;
  localparam logic [1:0] REG_TMA  = 2'd2;
  localparam logic [1:0] REG_TAC  = 2'd3;

  localparam int EnableBit = 2;

  // Divider mask per clock select: taps at bits 10, 4, 6, 8
  localparam logic [DivW-1:0] SEL_MASK [4] = '{16'hfc00, 16'hfff0, 16'hffc0, 16'hff00};

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ByteW-1:0] cycles;
    logic [1:0]       reg_index;
    logic [ByteW-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] read_data;
    logic             timer_irq;
  } result_t;

endpackage

### rtl/prescaled_timer_with_reload.sv
// Prescaled timer with reload: one result per transfer, through an input register,
// then a result register; throughput one transfer per cycle while m_tready is high.
// The rate is set by the combinational update in prt_core between the two registers;
// both sides stall independently without a bubble while the output drains.
// Synchronous active-high rst clears divider, counter, modulo, control and
// both valid flags.
module prescaled_timer_with_reload (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] cycles, [15:8] write_data
  input  logic [3:0]  s_tuser,   // [1:0] cmd, [3:2] reg_index
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] read_data
  output logic [0:0]  m_tuser    // [0] timer_irq
);
  import prt_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    go;
  result_t core_res;

  // Fire the held transfer when the result register is empty or draining.
  assign go       = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd        <= s_tuser[1:0];
      in_item.reg_index  <= s_tuser[3:2];
      in_item.cycles     <= s_tdata[7:0];
      in_item.write_data <= s_tdata[15:8];
    end
    if (go) begin
      m_tdata    <= core_res.read_data;
      m_tuser[0] <= core_res.timer_irq;
    end
  end

  // State update happens exactly once per transfer, on go
  prt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (go),
    .item   (in_item),
    .result (core_res)
  );

endmodule

### rtl/prt_core.sv
// Timer state (divider, counter, modulo, control) and the per-transfer update logic.
module prt_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  prt_pkg::item_t  item,
  output prt_pkg::result_t result
);
  import prt_pkg::*;

  logic [DivW-1:0]  divider_count, divider_count_next;
  logic [ByteW-1:0] timer_count, timer_count_next;
  logic [ByteW-1:0] reload_value, reload_value_next;
  logic [CtrlW-1:0] control_bits, control_bits_next;

  logic [DivW-1:0]  div_after;
  logic [DivW-1:0]  sel_m;
  logic [DivW-1:0]  diff;
  logic [ByteW-1:0] inc;
  logic [ByteW:0]   sum;

  // Boundary crossings of the selected tap, wrap-safe via masked difference
  always_comb begin
    div_after = divider_count + {6'd0, item.cycles, 2'b00};
    sel_m     = SEL_MASK[control_bits[1:0]];
    diff      = (div_after & sel_m) - (divider_count & sel_m);
    case (control_bits[1:0])
      2'd0:    inc = {2'b00, diff[15:10]};
      2'd1:    inc = diff[11:4];
      2'd2:    inc = diff[13:6];
      default: inc = diff[15:8];
    endcase
    sum = {1'b0, timer_count} + {1'b0, inc};
  end

  always_comb begin
    divider_count_next = divider_count;
    timer_count_next   = timer_count;
    reload_value_next  = reload_value;
    control_bits_next  = control_bits;
    result             = '0;
    unique case (item.cmd)
      CMD_TICK: begin
        divider_count_next = div_after;
        if (control_bits[EnableBit]) begin
          if (sum[ByteW]) begin
            timer_count_next = sum[ByteW-1:0] + reload_value;
            result.timer_irq = 1'b1;
          end else begin
            timer_count_next = sum[ByteW-1:0];
          end
        end
      end
      CMD_READ: begin
        unique case (item.reg_index)
          REG_DIV:  result.read_data = divider_count[DivW-1 -: ByteW];
          REG_TIMA: result.read_data = timer_count;
          REG_TMA:  result.read_data = reload_value;
          REG_TAC:  result.read_data = {{(ByteW-CtrlW){1'b0}}, control_bits};
          default:  result.read_data = '0;
        endcase
      end
      CMD_WRITE: begin
        unique case (item.reg_index)
          REG_DIV:  divider_count_next = '0;
          REG_TIMA: timer_count_next   = item.write_data;
          REG_TMA:  reload_value_next  = item.write_data;
          REG_TAC:  control_bits_next  = item.write_data[CtrlW-1:0];
          default:  ;
        endcase
      end
      default: ;  // unused command: no effect
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_count <= '0;
      timer_count   <= '0;
      reload_value  <= '0;
      control_bits  <= '0;
    end else if (step) begin
      divider_count <= divider_count_next;
      timer_count   <= timer_count_next;
      reload_value  <= reload_value_next;
      control_bits  <= control_bits_next;
    end
  end

endmodule
